### src/tpt_pkg.sv
// Shared types and constants for the trapezoid profile timing block.
// Holds the item structs, phase and state codes and the fixed field widths.
// No dependencies.
package tpt_pkg;

	localparam int unsigned DATA_W        = 32;
	localparam int unsigned TRAV_W        = DATA_W + 1;
	localparam int unsigned PROD_W        = 2 * DATA_W;
	localparam int unsigned DVSR_W        = DATA_W + 3;
	localparam int unsigned FRAC_BITS_DEF = 16;
	localparam int unsigned DIV_W_DEF     = TRAV_W + 1 + FRAC_BITS_DEF;

	localparam logic [DVSR_W-1:0] DIVISOR_FIVE = DVSR_W'(5);
	localparam logic [DVSR_W-1:0] DIVISOR_TEN  = DVSR_W'(10);

	typedef enum logic [1:0] {
		PH_ACCEL  = 2'd0,
		PH_CRUISE = 2'd1,
		PH_DECEL  = 2'd2,
		PH_PAST   = 2'd3
	} phase_t;

	typedef enum logic [0:0] {
		REG_TOTAL_DISTANCE = 1'b0,
		REG_FEED_RATE      = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DRV_BT,
		ST_DRV_RS,
		ST_DRV_TF,
		ST_DRV_D10,
		ST_PHASE,
		ST_MUL,
		ST_SQRT,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic              restart;
		logic [DATA_W-1:0] segment_length;
	} seg_item_t;

	typedef struct packed {
		logic [DATA_W-1:0] point_time;
		phase_t            phase;
		logic              bad_config;
	} pt_item_t;

endpackage

### src/tpt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tpt_pkg for the divisor width.
module tpt_div #(
	parameter int unsigned DIVIDEND_W = tpt_pkg::DIV_W_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [DIVIDEND_W-1:0]       dividend,
	input  logic [tpt_pkg::DVSR_W-1:0]  divisor,
	output logic                        done,
	output logic [DIVIDEND_W-1:0]       quotient
);
	import tpt_pkg::*;

	localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [DVSR_W-1:0]     rem_q;
	logic [DVSR_W-1:0]     dvsr_q;
	logic [DIVIDEND_W-1:0] dq_q;
	logic [DVSR_W:0]       rem_sh;
	logic [DVSR_W:0]       diff;
	logic                  fits;

	assign rem_sh   = {rem_q, dq_q[DIVIDEND_W-1]};
	assign diff     = rem_sh - {1'b0, dvsr_q};
	assign fits     = rem_sh >= {1'b0, dvsr_q};
	assign done     = done_q;
	assign quotient = dq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			dvsr_q <= divisor;
			dq_q   <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], fits};
		end
	end

endmodule

### src/tpt_mul.sv
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on tpt_pkg for the operand and product widths.
module tpt_mul (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tpt_pkg::TRAV_W-1:0]  mcand,
	input  logic [tpt_pkg::DATA_W-1:0]  mplier,
	output logic                        done,
	output logic [tpt_pkg::PROD_W-1:0]  product
);
	import tpt_pkg::*;

	localparam int unsigned ACC_W = TRAV_W + DATA_W;
	localparam int unsigned CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [TRAV_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [ACC_W-1:0]  acc_q;
	logic [TRAV_W:0]   part;

	assign part    = {1'b0, acc_q[ACC_W-1:DATA_W]} + {1'b0, (b_q[0] ? a_q : '0)};
	assign done    = done_q;
	assign product = acc_q[PROD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= mcand;
			b_q   <= mplier;
			acc_q <= '0;
		end else if (busy_q) begin
			b_q   <= b_q >> 1;
			acc_q <= {part, acc_q[DATA_W-1:1]};
		end
	end

endmodule

### src/tpt_sqrt.sv
// Digit-by-digit integer square root, one root bit per cycle.
// Depends on tpt_pkg for the radicand and root widths.
module tpt_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [tpt_pkg::PROD_W-1:0]  radicand,
	output logic                        done,
	output logic [tpt_pkg::DATA_W-1:0]  root
);
	import tpt_pkg::*;

	localparam int unsigned REM_W = DATA_W + 3;
	localparam int unsigned CNT_W = $clog2(DATA_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [PROD_W-1:0] x_q;
	logic [DATA_W-1:0] root_q;
	logic [REM_W-1:0]  rem_q;
	logic [REM_W-1:0]  rem_sh;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign rem_sh = {rem_q[DATA_W:0], x_q[PROD_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign fits   = rem_sh >= trial;
	assign done   = done_q;
	assign root   = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0) && !start;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DATA_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= radicand;
			root_q <= '0;
			rem_q  <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= fits ? (rem_sh - trial) : rem_sh;
			root_q <= {root_q[DATA_W-2:0], fits};
		end
	end

endmodule

### src/trapezoid_profile_timing.sv
// Trapezoid profile timing: arrival time of each path point on an LSPB profile.
// One item at a time: accelerate and decelerate use a serial multiply then a serial
// square root, cruise uses the serial divider, and the other phases use neither.
// A register write with both registers non-zero triggers four serial divisions,
// during which no item is accepted.
// Reset clears both registers, the derived values and the travelled distance.
module trapezoid_profile_timing #(
	parameter int unsigned FRAC_BITS = tpt_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  tpt_pkg::cfg_reg_t           cfg_idx,
	input  logic [tpt_pkg::DATA_W-1:0]  cfg_data,
	input  logic                        seg_valid,
	output logic                        seg_stall,
	input  tpt_pkg::seg_item_t          seg_item,
	output logic                        pt_valid,
	input  logic                        pt_stall,
	output tpt_pkg::pt_item_t           pt_item
);
	import tpt_pkg::*;

	localparam int unsigned DIV_W = TRAV_W + 1 + FRAC_BITS;
	localparam int unsigned TEN_W = TRAV_W + 4;

	state_t            state_q;
	state_t            state_d;
	logic [DATA_W-1:0] total_q;
	logic [DATA_W-1:0] feed_q;
	logic [DATA_W-1:0] bt_q;
	logic [DATA_W-1:0] rs_q;
	logic [DATA_W-1:0] tf_q;
	logic [DATA_W-1:0] d10_q;
	logic [TRAV_W-1:0] trav_q;
	logic              drv_req_q;
	logic [DATA_W-1:0] res_time_q;
	phase_t            res_phase_q;
	logic              res_bad_q;
	logic              pt_valid_q;
	pt_item_t          pt_item_q;

	logic              div_start;
	logic [DIV_W-1:0]  div_dividend;
	logic [DVSR_W-1:0] div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quot;
	logic              mul_start;
	logic [TRAV_W-1:0] mul_a;
	logic              mul_done;
	logic [PROD_W-1:0] mul_prod;
	logic              sqrt_start;
	logic              sqrt_done;
	logic [DATA_W-1:0] sqrt_root;

	logic              seg_acc;
	logic              out_free;
	logic              cfg_bad;
	logic [DATA_W-1:0] div_q_sat;
	logic [DVSR_W-1:0] feed5;
	logic [DVSR_W-1:0] bt6;
	logic [TEN_W-1:0]  ten_s;
	logic [TEN_W-1:0]  nine_total;
	logic [TRAV_W-1:0] decel_dist;
	logic [TRAV_W:0]   trav_sum;
	logic [TRAV_W-1:0] trav_next;
	logic [DIV_W:0]    cruise_sum;
	logic [DATA_W-1:0] cruise_time;
	logic [DATA_W-1:0] decel_time;
	phase_t            phase_sel;

	assign seg_acc   = seg_valid && !seg_stall;
	assign seg_stall = (state_q != ST_IDLE) || drv_req_q || cfg_we;
	assign out_free  = !pt_valid_q || !pt_stall;
	assign pt_valid  = pt_valid_q;
	assign pt_item   = pt_item_q;
	assign cfg_bad   = (total_q == '0) || (feed_q == '0);

	assign div_q_sat  = (|div_quot[DIV_W-1:DATA_W]) ? '1 : div_quot[DATA_W-1:0];
	assign feed5      = (DVSR_W'(feed_q) << 2) + DVSR_W'(feed_q);
	assign bt6        = (DVSR_W'(bt_q) << 2) + (DVSR_W'(bt_q) << 1);
	assign ten_s      = (TEN_W'(trav_q) << 3) + (TEN_W'(trav_q) << 1);
	assign nine_total = (TEN_W'(total_q) << 3) + TEN_W'(total_q);
	assign decel_dist = TRAV_W'(total_q) - trav_q;
	assign trav_sum   = (TRAV_W + 1)'(trav_q) + (TRAV_W + 1)'(seg_item.segment_length);
	assign trav_next  = seg_item.restart ? TRAV_W'(seg_item.segment_length)
		: (trav_sum[TRAV_W] ? '1 : trav_sum[TRAV_W-1:0]);
	assign cruise_sum  = (DIV_W + 1)'(div_quot) + (DIV_W + 1)'(d10_q);
	assign cruise_time = (|cruise_sum[DIV_W:DATA_W]) ? '1 : cruise_sum[DATA_W-1:0];
	assign decel_time  = (tf_q > sqrt_root) ? (tf_q - sqrt_root) : '0;

	always_comb begin
		if (ten_s < TEN_W'(total_q)) begin
			phase_sel = PH_ACCEL;
		end else if (ten_s < nine_total) begin
			phase_sel = PH_CRUISE;
		end else if (trav_q <= TRAV_W'(total_q)) begin
			phase_sel = PH_DECEL;
		end else begin
			phase_sel = PH_PAST;
		end
	end

	tpt_div #(
		.DIVIDEND_W(DIV_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quot)
	);

	tpt_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (mul_a),
		.mplier  (rs_q),
		.done    (mul_done),
		.product (mul_prod)
	);

	tpt_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (mul_prod),
		.done     (sqrt_done),
		.root     (sqrt_root)
	);

	always_comb begin
		state_d      = state_q;
		div_start    = 1'b0;
		div_dividend = DIV_W'(trav_q) << FRAC_BITS;
		div_divisor  = DVSR_W'(feed_q);
		mul_start    = 1'b0;
		mul_a        = trav_q;
		sqrt_start   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (drv_req_q) begin
					if (!cfg_bad) begin
						div_start    = 1'b1;
						div_dividend = DIV_W'(total_q) << FRAC_BITS;
						state_d      = ST_DRV_BT;
					end
				end else if (seg_acc) begin
					state_d = ST_PHASE;
				end
			end
			ST_DRV_BT: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'({div_q_sat, 1'b0}) << FRAC_BITS;
					div_divisor  = feed5;
					state_d      = ST_DRV_RS;
				end
			end
			ST_DRV_RS: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(bt6);
					div_divisor  = DIVISOR_FIVE;
					state_d      = ST_DRV_TF;
				end
			end
			ST_DRV_TF: begin
				if (div_done) begin
					div_start    = 1'b1;
					div_dividend = DIV_W'(bt_q);
					div_divisor  = DIVISOR_TEN;
					state_d      = ST_DRV_D10;
				end
			end
			ST_DRV_D10: begin
				if (div_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_PHASE: begin
				if (cfg_bad) begin
					state_d = ST_DONE;
				end else begin
					case (phase_sel)
						PH_ACCEL: begin
							mul_start = 1'b1;
							state_d   = ST_MUL;
						end
						PH_CRUISE: begin
							div_start = 1'b1;
							state_d   = ST_DIV;
						end
						PH_DECEL: begin
							mul_start = 1'b1;
							mul_a     = decel_dist;
							state_d   = ST_MUL;
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_MUL: begin
				if (mul_done) begin
					sqrt_start = 1'b1;
					state_d    = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (cfg_we) begin
			state_d = ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			total_q    <= '0;
			feed_q     <= '0;
			bt_q       <= '0;
			rs_q       <= '0;
			tf_q       <= '0;
			d10_q      <= '0;
			trav_q     <= '0;
			drv_req_q  <= 1'b0;
			pt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (drv_req_q) begin
						if (!cfg_we) begin
							drv_req_q <= 1'b0;
						end
						if (cfg_bad) begin
							bt_q  <= '0;
							rs_q  <= '0;
							tf_q  <= '0;
							d10_q <= '0;
						end
					end else if (seg_acc) begin
						trav_q <= trav_next;
					end
				end
				ST_DRV_BT: begin
					if (div_done) begin
						bt_q <= div_q_sat;
					end
				end
				ST_DRV_RS: begin
					if (div_done) begin
						rs_q <= div_q_sat;
					end
				end
				ST_DRV_TF: begin
					if (div_done) begin
						tf_q <= div_q_sat;
					end
				end
				ST_DRV_D10: begin
					if (div_done) begin
						d10_q <= div_quot[DATA_W-1:0];
					end
				end
				default: begin
				end
			endcase
			if (cfg_we) begin
				drv_req_q <= 1'b1;
				case (cfg_idx)
					REG_TOTAL_DISTANCE: total_q <= cfg_data;
					REG_FEED_RATE:      feed_q  <= cfg_data;
					default:            total_q <= total_q;
				endcase
			end
			if (state_q == ST_DONE && out_free) begin
				pt_valid_q <= 1'b1;
			end else if (!pt_stall) begin
				pt_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_PHASE: begin
				res_bad_q   <= cfg_bad;
				res_phase_q <= cfg_bad ? PH_ACCEL : phase_sel;
				res_time_q  <= cfg_bad ? '0 : tf_q;
			end
			ST_SQRT: begin
				if (sqrt_done) begin
					res_time_q <= (res_phase_q == PH_DECEL) ? decel_time : sqrt_root;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					res_time_q <= cruise_time;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					pt_item_q.point_time <= res_time_q;
					pt_item_q.phase      <= res_phase_q;
					pt_item_q.bad_config <= res_bad_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
